// File: rtl/kbd_dec_pkg.sv
// Shared types and constants of the keyboard scancode event decoder.
package kbd_dec_pkg;

  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned KEY_W       = 7;
  localparam int unsigned RELEASE_BIT = 7;

  localparam logic [KEY_W-1:0] KEY_LSHIFT = 7'h2A;
  localparam logic [KEY_W-1:0] KEY_RSHIFT = 7'h36;
  localparam logic [KEY_W-1:0] KEY_CTRL   = 7'h1D;
  localparam logic [KEY_W-1:0] KEY_ALT    = 7'h38;
  localparam logic [KEY_W-1:0] KEY_CAPS   = 7'h3A;

  typedef enum logic {
    CMD_SCAN = 1'b0,
    CMD_POLL = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_DOWN   = 2'd1,
    EV_UP     = 2'd2,
    EV_REPEAT = 2'd3
  } ev_type_e;

  typedef struct packed {
    ev_type_e         ev_type;
    logic [3:0]       mods;
    logic [KEY_W-1:0] key;
  } evt_word_t;

  typedef struct packed {
    logic      push;
    evt_word_t word;
    logic      led_send;
    logic      caps;
  } keymap_res_t;

  typedef struct packed {
    logic      push;
    logic      pop;
    evt_word_t wdata;
  } queue_req_t;

  typedef struct packed {
    evt_word_t        head_word;
    logic             empty;
    logic             full;
    logic [CNT_W-1:0] count_next;
  } queue_stat_t;

endpackage

// File: rtl/keyboard_scancode_event_decoder.sv
// Top level of the keyboard scancode event decoder.
//
// The input channel carries one request per transfer: a command bit and a raw
// set-1 scancode byte. A scan request updates the pressed-key map and the
// modifier flags and may queue a key event; a poll request pops the oldest
// queued event. Every request yields exactly one result on the output channel,
// carrying the polled event, the LED update flag and status, an overflow flag
// and the number of events still queued.
// A request is captured in an input register and processed from there into
// the result register when that is free. One request is taken in every cycle
// while the receiver does not stall; the rate is set by the single pass
// through the key map and one access to the event queue.
// When the receiver stalls, the held result stays put, one further request
// waits in the input register, and input ready drops once both are occupied.
// Reset clears the key map, the modifier and caps flags and the queue
// pointers at once; the block is ready as soon as reset is released.
module keyboard_scancode_event_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       command_i,
  input  logic [7:0] scan_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] event_type_o,
  output logic [3:0] modifier_bits_o,
  output logic [6:0] event_key_o,
  output logic       led_send_o,
  output logic [2:0] lock_leds_o,
  output logic       overflow_o,
  output logic [6:0] pending_count_o
);
  import kbd_dec_pkg::*;

  logic        in_valid_q;
  logic        cmd_q;
  logic [7:0]  byte_q;
  logic        out_valid_q;
  logic        fire;
  logic        accept;
  logic        poll_hit;
  keymap_res_t km_res;
  queue_req_t  q_req;
  queue_stat_t q_stat;

  logic [1:0]  event_type_q;
  logic [3:0]  modifier_bits_q;
  logic [6:0]  event_key_q;
  logic        led_send_q;
  logic [2:0]  lock_leds_q;
  logic        overflow_q;
  logic [6:0]  pending_count_q;

  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;
  assign accept     = in_valid_i && in_ready_o;
  assign poll_hit   = (cmd_q == CMD_POLL) && !q_stat.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= command_i;
      byte_q <= scan_byte_i;
    end
  end

  kbd_dec_keymap u_keymap (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (fire),
    .command_i  (cmd_q),
    .scan_byte_i(byte_q),
    .res_o      (km_res)
  );

  always_comb begin
    q_req.push  = fire && km_res.push && !q_stat.full;
    q_req.pop   = fire && poll_hit;
    q_req.wdata = km_res.word;
  end

  kbd_dec_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (q_req),
    .stat_o(q_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      if (poll_hit) begin
        event_type_q    <= q_stat.head_word.ev_type;
        modifier_bits_q <= q_stat.head_word.mods;
        event_key_q     <= q_stat.head_word.key;
      end else begin
        event_type_q    <= EV_NONE;
        modifier_bits_q <= '0;
        event_key_q     <= '0;
      end
      led_send_q      <= km_res.led_send;
      lock_leds_q     <= {km_res.caps, 2'b00};
      overflow_q      <= fire && km_res.push && q_stat.full;
      pending_count_q <= 7'(q_stat.count_next);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_type_o    = event_type_q;
  assign modifier_bits_o = modifier_bits_q;
  assign event_key_o     = event_key_q;
  assign led_send_o      = led_send_q;
  assign lock_leds_o     = lock_leds_q;
  assign overflow_o      = overflow_q;
  assign pending_count_o = pending_count_q;

endmodule

// File: rtl/kbd_dec_keymap.sv
// Pressed-key map, modifier tracking and scancode classification.
module kbd_dec_keymap (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      command_i,
  input  logic [7:0]                scan_byte_i,
  output kbd_dec_pkg::keymap_res_t  res_o
);
  import kbd_dec_pkg::*;

  logic [127:0]     pressed_q, pressed_d;
  logic             shift_q, shift_d;
  logic             ctrl_q, ctrl_d;
  logic             alt_q, alt_d;
  logic             caps_q, caps_d;
  logic [KEY_W-1:0] key;
  logic             released;
  logic             scan_step;
  logic             is_shift, is_ctrl, is_alt, is_caps;
  logic             led_send;

  assign key       = scan_byte_i[KEY_W-1:0];
  assign released  = scan_byte_i[RELEASE_BIT];
  assign scan_step = (command_i == CMD_SCAN);

  always_comb begin
    is_shift = 1'b0;
    is_ctrl  = 1'b0;
    is_alt   = 1'b0;
    is_caps  = 1'b0;
    unique case (key) inside
      KEY_LSHIFT, KEY_RSHIFT: is_shift = 1'b1;
      KEY_CTRL:               is_ctrl  = 1'b1;
      KEY_ALT:                is_alt   = 1'b1;
      KEY_CAPS:               is_caps  = 1'b1;
      default: ;
    endcase
  end

  assign led_send = scan_step && !released && is_caps;

  always_comb begin
    pressed_d = pressed_q;
    shift_d   = shift_q;
    ctrl_d    = ctrl_q;
    alt_d     = alt_q;
    caps_d    = caps_q ^ led_send;
    if (scan_step) begin
      pressed_d[key] = !released;
      if (is_shift) begin
        shift_d = !released;
      end
      if (is_ctrl) begin
        ctrl_d = !released;
      end
      if (is_alt) begin
        alt_d = !released;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q <= '0;
      shift_q   <= 1'b0;
      ctrl_q    <= 1'b0;
      alt_q     <= 1'b0;
      caps_q    <= 1'b0;
    end else if (en_i) begin
      pressed_q <= pressed_d;
      shift_q   <= shift_d;
      ctrl_q    <= ctrl_d;
      alt_q     <= alt_d;
      caps_q    <= caps_d;
    end
  end

  always_comb begin
    res_o.push = scan_step && !is_shift && !is_ctrl && !is_alt && !(is_caps && !released);
    if (released) begin
      res_o.word.ev_type = EV_UP;
    end else if (pressed_q[key]) begin
      res_o.word.ev_type = EV_REPEAT;
    end else begin
      res_o.word.ev_type = EV_DOWN;
    end
    res_o.word.mods = {caps_q, alt_q, ctrl_q, shift_q};
    res_o.word.key  = key;
    res_o.led_send  = led_send;
    res_o.caps      = caps_d;
  end

endmodule

// File: rtl/kbd_dec_queue.sv
// Event FIFO with a look-ahead registered read of the oldest entry.
module kbd_dec_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  kbd_dec_pkg::queue_req_t   req_i,
  output kbd_dec_pkg::queue_stat_t  stat_o
);
  import kbd_dec_pkg::*;

  evt_word_t        mem [QUEUE_DEPTH];
  evt_word_t        rd_q;
  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] res;
    if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = ptr + PTR_W'(1);
    end
    return res;
  endfunction

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (req_i.push) begin
      tail_d  = next_slot(tail_q);
      count_d = count_q + CNT_W'(1);
    end else if (req_i.pop) begin
      head_d  = next_slot(head_q);
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem[tail_q] <= req_i.wdata;
    end
  end

  // The entry at the next head is fetched ahead; a write to that slot is forwarded.
  always_ff @(posedge clk_i) begin
    if (req_i.push && (tail_q == head_d)) begin
      rd_q <= req_i.wdata;
    end else begin
      rd_q <= mem[head_d];
    end
  end

  assign stat_o.head_word  = rd_q;
  assign stat_o.empty      = (count_q == '0);
  assign stat_o.full       = (count_q == CNT_W'(QUEUE_DEPTH));
  assign stat_o.count_next = count_d;

endmodule

// File: rtl/kbd_dec_checker.sv
// Port-level checks of the keyboard scancode event decoder and their binding.
module kbd_dec_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       command_i,
  input logic [7:0] scan_byte_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] event_type_o,
  input logic [3:0] modifier_bits_o,
  input logic [6:0] event_key_o,
  input logic       led_send_o,
  input logic [2:0] lock_leds_o,
  input logic       overflow_o,
  input logic [6:0] pending_count_o
);
  import kbd_dec_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pending_count_o))
    else $error("result withdrawn or changed while stalled");

  a_poll_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_type_o != EV_NONE) |-> !led_send_o && !overflow_o)
    else $error("polled event carries scan-step flags");

  a_led_only_on_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && led_send_o |->
      (event_type_o == EV_NONE) && (event_key_o == '0) && (modifier_bits_o == '0)
      && lock_leds_o[1:0] == 2'b00)
    else $error("LED update result carries event fields");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> pending_count_o == 7'(QUEUE_DEPTH))
    else $error("overflow reported with queue not full");

  a_stall_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && in_valid_i && in_ready_o |=> !in_ready_o || out_ready_i)
    else $error("input accepted beyond buffering while stalled");

endmodule

bind keyboard_scancode_event_decoder kbd_dec_checker u_kbd_dec_checker (.*);
